FILE: sv/assert_macros.svh
// Assertion macros shared by the vertex normal accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VNA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VNA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/vna_pkg.sv
// Types and constants shared by the vertex normal accumulator modules.
package vna_pkg;

    localparam int IDX_W   = 10;  // vertex index field
    localparam int POS_W   = 20;  // Q10.10 coordinate
    localparam int EDGE_W  = 21;  // coordinate difference
    localparam int PROD_W  = 42;  // edge product
    localparam int CROSS_W = 43;  // cross product component
    localparam int SUM_W   = 24;  // Q9.14 normal sum
    localparam int NORM_W  = 16;  // Q1.14 unit component
    localparam int MAG_W   = 44;  // magnitude before scaling
    localparam int SCL_W   = 30;  // magnitude after scaling
    localparam int SQ_W    = 64;  // square sum and root work registers
    localparam int DIV_W   = 46;  // divider remainder and divisor
    localparam int Q_W     = 15;  // quotient bits
    localparam int CNT_W   = 5;   // iteration counter
    localparam int UNIT_SHIFT = 14;

    localparam logic [CNT_W-1:0] SQRT_LAST_CNT = CNT_W'(31);
    localparam logic [CNT_W-1:0] DIV_LAST_CNT  = CNT_W'(Q_W - 1);
    localparam logic [Q_W-1:0]   UNIT_ONE      = Q_W'(16384);
    localparam logic [SQ_W-1:0]  SQRT_TOP_BIT  = SQ_W'(1) << 62;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_TRI   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_CLEAR, OP_LOAD, OP_WR_POS, OP_RD_POS, OP_LAT_POS, OP_EDGE,
        OP_MUL1, OP_MUL2, OP_RD_SUM, OP_LD_VEC, OP_MAG, OP_SHIFT, OP_SQ,
        OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
        OP_SUM_WR, OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISP, ST_WRP, ST_RDP, ST_LATP, ST_EDGE, ST_MUL1,
        ST_MUL2, ST_RDS, ST_WTS, ST_LDV, ST_MAG, ST_SHIFT, ST_SQ, ST_SQRTI,
        ST_SQRT, ST_DIVI, ST_DIV, ST_DIVE, ST_ADDS, ST_OUT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;   // component or corner (0 = first corner)
    } vna_cmd_t;

    typedef struct packed {
        logic clear_last;
        req_t req;
        logic ia_ok;
        logic all_ok;
        logic zero_vec;
        logic norm_ok;
        logic iter_last;
        logic out_busy;
    } vna_stat_t;

endpackage

FILE: sv/vertex_normal_accumulator.sv
// Top level of the vertex normal accumulator: stream ports, controller and datapath.
//
//  channel | dir | tdata (low bit up)                                  | tuser
//  s_      | in  | vert_index, corner_b, corner_c, pos_x, pos_y, pos_z | req_type
//  m_      | out | norm_x, norm_y, norm_z                              | zero_length, sum_saturated
//
// One item at a time: the next item is not accepted until this one's result is
// registered. Reads and triangles take longest; the bit-serial square root (32
// steps), the three 15-step divides and the one-bit-per-cycle scaling shifter set that.
// After reset a clearing pass zeroes every sum memory entry; no
// item is accepted during it. A stalled result waits in the output register.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // vert_index, corner_b, corner_c, pos_x, pos_y, pos_z
    input  logic [1:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // norm_x, norm_y, norm_z
    output logic [1:0]  m_tuser   // zero_length, sum_saturated
);
    import vna_pkg::*;

    vna_cmd_t  cmd;
    vna_stat_t stat;
    logic      zero_flag, sat_flag;

    vna_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vna_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_req   (s_tuser),
        .in_ia    (s_tdata[9:0]),
        .in_ib    (s_tdata[19:10]),
        .in_ic    (s_tdata[29:20]),
        .in_px    (s_tdata[49:30]),
        .in_py    (s_tdata[69:50]),
        .in_pz    (s_tdata[89:70]),
        .m_tready (m_tready),
        .m_valid  (m_tvalid),
        .out_norm (m_tdata),
        .out_zero (zero_flag),
        .out_sat  (sat_flag)
    );

    assign m_tuser = {sat_flag, zero_flag};

endmodule

FILE: sv/vna_ctrl.sv
// Controller state machine sequencing the accumulator datapath.
module vna_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  vna_pkg::vna_stat_t stat,
    output vna_pkg::vna_cmd_t  cmd
);
    import vna_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;

    // state and component registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            k_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd.op     = OP_IDLE;
        cmd.sel    = k_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (stat.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                k_next = 2'd0;
                unique case (stat.req)
                    REQ_WRITE: state_next = stat.ia_ok ? ST_WRP : ST_OUT;
                    REQ_TRI:   state_next = stat.all_ok ? ST_RDP : ST_OUT;
                    REQ_READ:  state_next = stat.ia_ok ? ST_RDS : ST_OUT;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_WRP: begin
                cmd.op     = OP_WR_POS;
                state_next = ST_OUT;
            end
            ST_RDP: begin
                cmd.op     = OP_RD_POS;
                state_next = ST_LATP;
            end
            ST_LATP: begin
                cmd.op = OP_LAT_POS;
                if (k_reg == 2'd2) begin
                    k_next     = 2'd0;
                    state_next = ST_EDGE;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_RDP;
                end
            end
            ST_EDGE: begin
                cmd.op     = OP_EDGE;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.op = OP_MUL2;
                if (k_reg == 2'd2) begin
                    k_next     = 2'd0;
                    state_next = ST_MAG;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_MUL1;
                end
            end
            ST_RDS: begin
                cmd.op     = OP_RD_SUM;
                state_next = ST_WTS;
            end
            ST_WTS: begin
                state_next = (stat.req == REQ_TRI) ? ST_ADDS : ST_LDV;
            end
            ST_ADDS: begin
                cmd.op = OP_SUM_WR;
                if (k_reg == 2'd2) begin
                    state_next = ST_OUT;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_RDS;
                end
            end
            ST_LDV: begin
                cmd.op     = OP_LD_VEC;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                cmd.op     = OP_MAG;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                k_next = 2'd0;
                if (stat.zero_vec) state_next = ST_OUT;
                else if (stat.norm_ok) state_next = ST_SQ;
                else cmd.op = OP_SHIFT;
            end
            ST_SQ: begin
                cmd.op = OP_SQ;
                if (k_reg == 2'd2) begin
                    k_next     = 2'd0;
                    state_next = ST_SQRTI;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_SQRTI: begin
                cmd.op     = OP_SQRT_INIT;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op = OP_SQRT_STEP;
                if (stat.iter_last) state_next = ST_DIVI;
            end
            ST_DIVI: begin
                cmd.op     = OP_DIV_INIT;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (stat.iter_last) state_next = ST_DIVE;
            end
            ST_DIVE: begin
                cmd.op = OP_DIV_END;
                if (k_reg == 2'd2) begin
                    k_next     = 2'd0;
                    state_next = (stat.req == REQ_TRI) ? ST_RDS : ST_OUT;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_DIVI;
                end
            end
            ST_OUT: begin
                if (!stat.out_busy) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/vna_datapath.sv
// Datapath: position and sum memories, cross product, normalizer, output register.
`include "assert_macros.svh"
module vna_datapath #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  vna_pkg::vna_cmd_t                cmd,
    output vna_pkg::vna_stat_t               stat,
    input  logic [1:0]                       in_req,
    input  logic [vna_pkg::IDX_W-1:0]        in_ia,
    input  logic [vna_pkg::IDX_W-1:0]        in_ib,
    input  logic [vna_pkg::IDX_W-1:0]        in_ic,
    input  logic signed [vna_pkg::POS_W-1:0] in_px,
    input  logic signed [vna_pkg::POS_W-1:0] in_py,
    input  logic signed [vna_pkg::POS_W-1:0] in_pz,
    input  logic                             m_tready,
    output logic                             m_valid,
    output logic [3*vna_pkg::NORM_W-1:0]     out_norm,
    output logic                             out_zero,
    output logic                             out_sat
);
    import vna_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [XW-1:0] ext;
        begin
            ext = XW'(idx);
            return ext[AW-1:0];
        end
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return {22'd0, idx} < 32'(MAX_VERTICES);
    endfunction

    // memories
    logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
    logic [3*SUM_W-1:0] sum_mem [MAX_VERTICES];
    logic [3*POS_W-1:0] pos_rd_reg;
    logic [3*SUM_W-1:0] sum_rd_reg;

    // item registers
    req_t                    req_reg;
    logic [IDX_W-1:0]        ia_reg, ib_reg, ic_reg;
    logic [3*POS_W-1:0]      wpos_reg;
    logic [3*POS_W-1:0]      pos_reg [3];
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic signed [PROD_W-1:0] p_reg;
    logic signed [CROSS_W-1:0] v_reg [3];
    logic [MAG_W-1:0]        mag_reg [3];
    logic [MAG_W-1:0]        max_reg;
    logic [2:0]              sign_reg;
    logic [SQ_W-1:0]         acc_reg, x_reg, res_reg, bit_reg;
    logic [DIV_W-1:0]        rem_reg, dvs_reg;
    logic [Q_W-1:0]          q_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [NORM_W-1:0] n_reg [3];
    logic                    zero_reg, clip_reg;
    logic [AW-1:0]           clr_reg;
    logic                    m_valid_reg;
    logic [3*NORM_W-1:0]     onorm_reg;
    logic                    ozero_reg, osat_reg;

    // corner select and addresses
    logic [IDX_W-1:0] cidx;
    logic [AW-1:0]    addr_c;
    always_comb begin
        case (cmd.sel)
            2'd1:    cidx = ib_reg;
            2'd2:    cidx = ic_reg;
            default: cidx = ia_reg;
        endcase
        addr_c = to_addr(cidx);
    end

    // shared edge multiplier
    logic [1:0] j1, j2;
    logic signed [EDGE_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    always_comb begin
        case (cmd.sel)
            2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
            2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
            default: begin j1 = 2'd0; j2 = 2'd1; end
        endcase
        if (cmd.op == OP_MUL2) begin
            mul_a = e1_reg[j2];
            mul_b = e2_reg[j1];
        end else begin
            mul_a = e1_reg[j1];
            mul_b = e2_reg[j2];
        end
        prod = mul_a * mul_b;
    end

    // magnitudes and largest
    logic [MAG_W-1:0] mag_in [3];
    logic [MAG_W-1:0] mx;
    always_comb begin
        logic signed [MAG_W-1:0] ve;
        for (int i = 0; i < 3; i++) begin
            ve = MAG_W'(v_reg[i]);
            mag_in[i] = ve[MAG_W-1] ? MAG_W'(-ve) : MAG_W'(ve);
        end
        mx = mag_in[0];
        if (mag_in[1] > mx) mx = mag_in[1];
        if (mag_in[2] > mx) mx = mag_in[2];
    end

    // square, root step and divide step
    logic [SCL_W-1:0] sq_op;
    logic [2*SCL_W-1:0] sq_prod;
    logic [SQ_W-1:0] rt_try;
    logic [Q_W-1:0] q_out;
    assign sq_op   = mag_reg[cmd.sel][SCL_W-1:0];
    assign sq_prod = sq_op * sq_op;
    assign rt_try  = res_reg + bit_reg;
    assign q_out   = q_reg;

    // saturating corner adds
    logic [3*SUM_W-1:0] sum_new;
    logic               clip_now;
    always_comb begin
        logic signed [SUM_W:0] s;
        logic signed [SUM_W-1:0] old;
        clip_now = 1'b0;
        for (int i = 0; i < 3; i++) begin
            old = sum_rd_reg[i*SUM_W +: SUM_W];
            s = (SUM_W+1)'(old) + (SUM_W+1)'(n_reg[i]);
            if (s[SUM_W] != s[SUM_W-1]) begin
                clip_now = 1'b1;
                sum_new[i*SUM_W +: SUM_W] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                      : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sum_new[i*SUM_W +: SUM_W] = s[SUM_W-1:0];
            end
        end
    end

    // sum memory write port
    logic               sum_we;
    logic [AW-1:0]      sum_waddr;
    logic [3*SUM_W-1:0] sum_wdata;
    always_comb begin
        sum_we    = 1'b0;
        sum_waddr = addr_c;
        sum_wdata = sum_new;
        case (cmd.op)
            OP_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
                sum_wdata = '0;
            end
            OP_WR_POS: begin
                sum_we    = 1'b1;
                sum_waddr = to_addr(ia_reg);
                sum_wdata = '0;
            end
            OP_SUM_WR: sum_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
        if (cmd.op == OP_RD_SUM) sum_rd_reg <= sum_mem[addr_c];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WR_POS) pos_mem[to_addr(ia_reg)] <= wpos_reg;
        if (cmd.op == OP_RD_POS) pos_rd_reg <= pos_mem[addr_c];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            clr_reg     <= '0;
        end else begin
            if (cmd.op == OP_OUT) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            if (cmd.op == OP_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                req_reg  <= req_t'(in_req);
                ia_reg   <= in_ia;
                ib_reg   <= in_ib;
                ic_reg   <= in_ic;
                wpos_reg <= {in_pz, in_py, in_px};
                zero_reg <= (req_t'(in_req) == REQ_READ) && !in_range(in_ia);
                clip_reg <= 1'b0;
                for (int i = 0; i < 3; i++) n_reg[i] <= '0;
            end
            OP_LAT_POS: pos_reg[cmd.sel] <= pos_rd_reg;
            OP_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    e1_reg[i] <= EDGE_W'($signed(pos_reg[1][i*POS_W +: POS_W]))
                               - EDGE_W'($signed(pos_reg[0][i*POS_W +: POS_W]));
                    e2_reg[i] <= EDGE_W'($signed(pos_reg[2][i*POS_W +: POS_W]))
                               - EDGE_W'($signed(pos_reg[0][i*POS_W +: POS_W]));
                end
            end
            OP_MUL1: p_reg <= prod;
            OP_MUL2: v_reg[cmd.sel] <= CROSS_W'(p_reg) - CROSS_W'(prod);
            OP_LD_VEC: begin
                for (int i = 0; i < 3; i++)
                    v_reg[i] <= CROSS_W'($signed(sum_rd_reg[i*SUM_W +: SUM_W]));
            end
            OP_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i]  <= mag_in[i];
                    sign_reg[i] <= v_reg[i][CROSS_W-1];
                end
                max_reg  <= mx;
                zero_reg <= (mx == '0);
            end
            OP_SHIFT: begin
                if (max_reg[MAG_W-1:SCL_W] != '0) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    max_reg <= max_reg >> 1;
                end else begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    max_reg <= max_reg << 1;
                end
            end
            OP_SQ: begin
                if (cmd.sel == 2'd0) acc_reg <= SQ_W'(sq_prod);
                else acc_reg <= acc_reg + SQ_W'(sq_prod);
            end
            OP_SQRT_INIT: begin
                x_reg   <= acc_reg;
                res_reg <= '0;
                bit_reg <= SQRT_TOP_BIT;
                cnt_reg <= SQRT_LAST_CNT;
            end
            OP_SQRT_STEP: begin
                if (x_reg >= rt_try) begin
                    x_reg   <= x_reg - rt_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_DIV_INIT: begin
                rem_reg <= (DIV_W'(mag_reg[cmd.sel][SCL_W-1:0]) << UNIT_SHIFT)
                         + DIV_W'(res_reg >> 1);
                dvs_reg <= DIV_W'(res_reg) << UNIT_SHIFT;
                q_reg   <= '0;
                cnt_reg <= DIV_LAST_CNT;
            end
            OP_DIV_STEP: begin
                if (rem_reg >= dvs_reg) begin
                    rem_reg <= rem_reg - dvs_reg;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
                dvs_reg <= dvs_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_DIV_END: begin
                n_reg[cmd.sel] <= sign_reg[cmd.sel] ? -NORM_W'(q_out) : NORM_W'(q_out);
            end
            OP_SUM_WR: clip_reg <= clip_reg | clip_now;
            OP_OUT: begin
                if (req_reg == REQ_READ)
                    onorm_reg <= {n_reg[2], n_reg[1], n_reg[0]};
                else
                    onorm_reg <= '0;
                ozero_reg <= zero_reg;
                osat_reg  <= clip_reg;
            end
            default: ;
        endcase
    end

    // status to controller
    always_comb begin
        stat.clear_last = (clr_reg == AW'(MAX_VERTICES - 1));
        stat.req        = req_reg;
        stat.ia_ok      = in_range(ia_reg);
        stat.all_ok     = in_range(ia_reg) && in_range(ib_reg) && in_range(ic_reg);
        stat.zero_vec   = zero_reg;
        stat.norm_ok    = (max_reg[MAG_W-1:SCL_W] == '0) && max_reg[SCL_W-1];
        stat.iter_last  = (cnt_reg == '0);
        stat.out_busy   = m_valid_reg && !m_tready;
    end

    assign m_valid  = m_valid_reg;
    assign out_norm = onorm_reg;
    assign out_zero = ozero_reg;
    assign out_sat  = osat_reg;

    `VNA_ASSERT_NXT(a_out_loads, aclk, aresetn, cmd.op == OP_OUT, m_valid_reg, "result lost")
    `VNA_ASSERT_IMP(a_q_bound, aclk, aresetn, cmd.op == OP_DIV_END, q_reg <= UNIT_ONE, "quotient above unit")
    `VNA_ASSERT_IMP(a_len_range, aclk, aresetn, cmd.op == OP_DIV_INIT, res_reg[SQ_W-1:SCL_W-1] != '0, "root below range")

endmodule

FILE: dv/vertex_normal_accumulator_checker.sv
// Checker for the vertex normal accumulator: predicts each result and compares it.
`timescale 1ns / 1ps
module vertex_normal_accumulator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,  // vert_index, corner_b, corner_c, pos_x, pos_y, pos_z
    input  logic [1:0]  s_tuser,  // req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,  // norm_x, norm_y, norm_z
    input  logic [1:0]  m_tuser,  // zero_length, sum_saturated
    output int          failures,
    output int          pending
);
    import vna_pkg::*;

    localparam int ACC_MAX = 8388607;
    localparam int ACC_MIN = -8388608;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               zero_len;
        logic               sat;
    } normal_t;

    int      vtx_pos [1024][3];
    int      acc_x [1024];
    int      acc_y [1024];
    int      acc_z [1024];
    normal_t expected_normals[$];

    // Scale the vector to a Q1.14 unit vector; all-zero input flags zero length.
    function automatic normal_t unit_vec(input longint vx, input longint vy, input longint vz);
        longint          v [3];
        longint unsigned mag [3];
        longint unsigned top;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned bitv;
        longint unsigned quo;
        int              q [3];
        normal_t         r;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > top) top = mag[i];
        end
        r = '0;
        if (top == 0) begin
            r.zero_len = 1'b1;
            return r;
        end
        while (top >= (64'd1 << 30)) begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (top < (64'd1 << 29)) begin
            top = top << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        // bitwise integer square root
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > sq) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (sq >= root + bitv) begin
                sq   = sq - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        for (int i = 0; i < 3; i++) begin
            quo  = (mag[i] * 64'd16384 + root / 2) / root;
            q[i] = (v[i] < 0) ? -int'(quo) : int'(quo);
        end
        r.nx = 16'(q[0]);
        r.ny = 16'(q[1]);
        r.nz = 16'(q[2]);
        return r;
    endfunction

    function automatic int clip_add(input int a, input int b, inout logic clipped);
        int s;
        s = a + b;
        if (s > ACC_MAX) begin
            clipped = 1'b1;
            return ACC_MAX;
        end
        if (s < ACC_MIN) begin
            clipped = 1'b1;
            return ACC_MIN;
        end
        return s;
    endfunction

    // Apply one item to the shadow state and return its expected result.
    function automatic normal_t apply_item(input req_t req, input logic [95:0] d);
        int      ia;
        int      ic [3];
        longint  e1 [3];
        longint  e2 [3];
        normal_t f;
        normal_t r;
        logic    clipped;
        ia    = int'(d[9:0]);
        ic[0] = ia;
        ic[1] = int'(d[19:10]);
        ic[2] = int'(d[29:20]);
        r = '0;
        clipped = 1'b0;
        case (req)
            REQ_WRITE: begin
                vtx_pos[ia][0] = int'($signed(d[49:30]));
                vtx_pos[ia][1] = int'($signed(d[69:50]));
                vtx_pos[ia][2] = int'($signed(d[89:70]));
                acc_x[ia] = 0;
                acc_y[ia] = 0;
                acc_z[ia] = 0;
            end
            REQ_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    e1[i] = longint'(vtx_pos[ic[1]][i]) - vtx_pos[ic[0]][i];
                    e2[i] = longint'(vtx_pos[ic[2]][i]) - vtx_pos[ic[0]][i];
                end
                f = unit_vec(e1[1] * e2[2] - e1[2] * e2[1],
                             e1[2] * e2[0] - e1[0] * e2[2],
                             e1[0] * e2[1] - e1[1] * e2[0]);
                if (f.zero_len) begin
                    r.zero_len = 1'b1;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        acc_x[ic[k]] = clip_add(acc_x[ic[k]], int'(f.nx), clipped);
                        acc_y[ic[k]] = clip_add(acc_y[ic[k]], int'(f.ny), clipped);
                        acc_z[ic[k]] = clip_add(acc_z[ic[k]], int'(f.nz), clipped);
                    end
                end
                r.sat = clipped;
            end
            REQ_READ: begin
                r = unit_vec(acc_x[ia], acc_y[ia], acc_z[ia]);
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        failures = 0;
        pending  = 0;
        for (int i = 0; i < 1024; i++) begin
            acc_x[i] = 0;
            acc_y[i] = 0;
            acc_z[i] = 0;
            for (int j = 0; j < 3; j++) vtx_pos[i][j] = 0;
        end
    end

    // Compare results first, then predict from the item taken at the same edge.
    always @(posedge aclk) begin
        normal_t got;
        normal_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0], m_tuser[1]};
                if (expected_normals.size() == 0) begin
                    failures = failures + 1;
                    if (failures <= 10)
                        $display("%0t: unexpected result %h", $time, got);
                end else begin
                    want = expected_normals.pop_front();
                    if (got !== want) begin
                        failures = failures + 1;
                        if (failures <= 10) begin
                            $write("%0t: mismatch exp n=(%0d %0d %0d) zl=%b sat=%b",
                                   $time, want.nx, want.ny, want.nz, want.zero_len,
                                   want.sat);
                            $display(" got n=(%0d %0d %0d) zl=%b sat=%b",
                                     got.nx, got.ny, got.nz, got.zero_len, got.sat);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_normals.insert(expected_normals.size(),
                                        apply_item(req_t'(s_tuser), s_tdata));
        end
        pending = expected_normals.size();
    end
endmodule

FILE: dv/vertex_normal_accumulator_tb.sv
// Testbench top for the vertex normal accumulator: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module vertex_normal_accumulator_tb;
    import vna_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;  // vert_index, corner_b, corner_c, pos_x, pos_y, pos_z
    logic [1:0]  s_tuser;  // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;  // norm_x, norm_y, norm_z
    logic [1:0]  m_tuser;  // zero_length, sum_saturated
    int          failures;
    int          pending;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          written [1024];
    int          written_list[$];
    int          n_writes, n_tris, n_reads, n_other;

    vertex_normal_accumulator dut (.*);
    vertex_normal_accumulator_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Result side backpressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Present one item and hold it until it is taken.
    task automatic send_item(input req_t req, input int ia, input int ib, input int ic,
                             input int px, input int py, input int pz);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, 20'(pz), 20'(py), 20'(px), 10'(ic), 10'(ib), 10'(ia)};
        do @(posedge aclk); while (!s_tready);
        case (req)
            REQ_WRITE: begin
                n_writes++;
                if (!written[ia]) written_list.insert(written_list.size(), ia);
                written[ia] = 1'b1;
            end
            REQ_TRI:  n_tris++;
            REQ_READ: n_reads++;
            default:  n_other++;
        endcase
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic int rnd_coord();
        return int'($signed(20'($urandom)));
    endfunction

    function automatic int pick_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    task automatic finish_run();
        drain();
        repeat (300) @(posedge aclk);
        $display("covered %0d writes, %0d triangles, %0d reads, %0d unused-type items",
                 n_writes, n_tris, n_reads, n_other);
        if (failures == 0)
            $display("vertex_normal_accumulator_tb OK");
        else
            $display("vertex_normal_accumulator_tb NOT OK");
        $finish;
    endtask

    // Run limit
    initial begin
        #40ms;
        $display("vertex_normal_accumulator_tb NOT OK");
        $finish;
    end

    initial begin
        int kind;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_NONE;
        m_tready = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 37;
        n_writes = 0;
        n_tris   = 0;
        n_reads  = 0;
        n_other  = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme positions, every request kind, degenerate faces
        send_item(REQ_WRITE, 0, 0, 0, 0, 0, 0);
        send_item(REQ_WRITE, 1, 1023, 1023, 524287, 0, 0);
        send_item(REQ_WRITE, 2, 0, 0, 0, 524287, 0);
        send_item(REQ_WRITE, 1023, 0, 0, -524288, -524288, -524288);
        send_item(REQ_WRITE, 3, 0, 0, 524287, 524287, 524287);
        send_item(REQ_TRI, 0, 1, 2, 0, 0, 0);
        send_item(REQ_TRI, 1023, 3, 1, 0, 0, 0);
        send_item(REQ_TRI, 1023, 1, 3, -1, -1, -1);
        send_item(REQ_TRI, 0, 0, 1, 0, 0, 0);        // zero-area: repeated corner
        send_item(REQ_TRI, 0, 3, 1023, 0, 0, 0);     // zero-area: collinear points
        send_item(REQ_TRI, 1, 1, 2, 0, 0, 0);        // zero-area but corner named twice
        send_item(REQ_READ, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READ, 1023, 0, 0, 0, 0, 0);
        send_item(REQ_READ, 3, 1023, 1023, -1, -1, -1);
        send_item(REQ_READ, 700, 0, 0, 0, 0, 0);     // never touched: zero length
        send_item(REQ_NONE, 1023, 1023, 1023, -1, -1, -1);
        send_item(REQ_NONE, 0, 0, 0, 0, 0, 0);
        send_item(REQ_WRITE, 0, 0, 0, 0, 0, 0);      // rewrite clears the sum
        send_item(REQ_READ, 0, 0, 0, 0, 0, 0);

        // Drain once with the sender held off
        drain();

        // Saturation: an axis-aligned face added until its corner sums clip
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_item(REQ_WRITE, 10, 0, 0, 0, 0, 0);
        send_item(REQ_WRITE, 11, 0, 0, 1024, 0, 0);
        send_item(REQ_WRITE, 12, 0, 0, 0, 1024, 0);
        for (int i = 0; i < 540; i++) begin
            if (i % 90 == 89) send_item(REQ_READ, 10 + i % 3, 0, 0, 0, 0, 0);
            else if (i < 530) send_item(REQ_TRI, 10, 11, 12, 0, 0, 0);
            else send_item(REQ_TRI, 10, 12, 11, 0, 0, 0);  // reverse winding
        end
        send_item(REQ_TRI, 10, 10, 12, 0, 0, 0);
        send_idle_pct = 37;
        recv_idle_pct = 37;

        // Random mix of well-formed requests over a small pool plus noise
        for (int i = 0; i < 600; i++) begin
            kind = $urandom_range(99);
            if (i == 300) begin
                drain();
            end
            if (kind < 25 || written_list.size() < 3)
                send_item(REQ_WRITE, ($urandom_range(3) == 0) ? $urandom_range(1023)
                          : $urandom_range(15), $urandom, $urandom,
                          ($urandom_range(3) == 0) ? rnd_coord() : rnd_coord() >>> 8,
                          ($urandom_range(3) == 0) ? rnd_coord() : rnd_coord() >>> 8,
                          rnd_coord());
            else if (kind < 72)
                send_item(REQ_TRI, pick_written(), pick_written(), pick_written(),
                          rnd_coord(), rnd_coord(), rnd_coord());
            else if (kind < 95)
                send_item(REQ_READ, ($urandom_range(4) == 0) ? $urandom_range(1023)
                          : pick_written(), $urandom, $urandom,
                          rnd_coord(), rnd_coord(), rnd_coord());
            else
                send_item(REQ_NONE, $urandom, $urandom, $urandom,
                          rnd_coord(), rnd_coord(), rnd_coord());
        end

        finish_run();
    end
endmodule
